### design/bmmg_pkg.sv
// Shared types, constants and tables for the button mouse motion generator.
// No dependencies; every other design file imports it.
package bmmg_pkg;

	localparam int NUM_DIRS   = 4;
	localparam int DIR_BTNS   = 4;
	localparam int PHASE_BITS = 16;
	localparam int FRAC_BITS  = PHASE_BITS - 3;
	localparam int SPEED_W    = 4;
	localparam int SUM_W      = 9;
	localparam int ANGLES     = 64;

	localparam longint unsigned STEP_VAL = ((64'd1 << FRAC_BITS) + 64'd10) / 64'd20;
	localparam longint unsigned WRAP_VAL =
		(64'd628318 * (64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;

	localparam logic [PHASE_BITS-1:0] PHASE_STEP = PHASE_BITS'(STEP_VAL);
	localparam logic [PHASE_BITS-1:0] PHASE_WRAP = PHASE_BITS'(WRAP_VAL);

	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(127);
	localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(127);

	// Quarter-wave sine in Q12
	localparam logic [12:0] QSIN [17] = '{
		13'd0, 13'd401, 13'd799, 13'd1189, 13'd1567, 13'd1931, 13'd2276, 13'd2598,
		13'd2896, 13'd3166, 13'd3406, 13'd3612, 13'd3784, 13'd3920, 13'd4017,
		13'd4076, 13'd4096
	};

	// Angle k starts at the smallest phase with phase*64 >= k*wrap
	typedef logic [PHASE_BITS-1:0] thr_tab_t [ANGLES];

	function automatic thr_tab_t build_thr();
		thr_tab_t t;
		longint unsigned v;
		for (int k = 0; k < ANGLES; k++) begin
			v = (longint'(k) * WRAP_VAL + 64'd63) >> 6;
			t[k] = PHASE_BITS'(v);
		end
		return t;
	endfunction

	localparam thr_tab_t ANGLE_THR = build_thr();

	typedef enum logic [2:0] {
		REG_TICK    = 3'd0,
		REG_TIER1   = 3'd1,
		REG_TIER2   = 3'd2,
		REG_TIER3   = 3'd3,
		REG_TIER4   = 3'd4,
		REG_LOCKOUT = 3'd5,
		REG_AMP     = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  tick_ms;
		logic [15:0] tier1_ms;
		logic [15:0] tier2_ms;
		logic [15:0] tier3_ms;
		logic [15:0] tier4_ms;
		logic [9:0]  lockout_ticks;
		logic [3:0]  amplitude;
	} cfg_t;

	// Per-request control fanned out to the lanes
	typedef struct packed {
		logic accept;
		logic manual;
	} lane_ctl_t;

	// Stage 1 payload passed to the merge stage
	typedef struct packed {
		logic                  report;
		logic                  circle;
		logic [PHASE_BITS-1:0] phase;
	} stage_t;

	typedef struct packed {
		logic       mode_led;
		logic [7:0] move_y;
		logic [7:0] move_x;
		logic       report_valid;
	} result_t;

endpackage

### design/bmmg_regs.sv
// APB-style register file holding the tick, tier, lockout and amplitude settings.
// Depends on bmmg_pkg.
module bmmg_regs import bmmg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_ms       <= 8'd2;
			cfg_q.tier1_ms      <= 16'd250;
			cfg_q.tier2_ms      <= 16'd500;
			cfg_q.tier3_ms      <= 16'd1000;
			cfg_q.tier4_ms      <= 16'd2000;
			cfg_q.lockout_ticks <= 10'd100;
			cfg_q.amplitude     <= 4'd3;
		end else if (wr) begin
			case (idx)
				REG_TICK:    cfg_q.tick_ms       <= pwdata[7:0];
				REG_TIER1:   cfg_q.tier1_ms      <= pwdata[15:0];
				REG_TIER2:   cfg_q.tier2_ms      <= pwdata[15:0];
				REG_TIER3:   cfg_q.tier3_ms      <= pwdata[15:0];
				REG_TIER4:   cfg_q.tier4_ms      <= pwdata[15:0];
				REG_LOCKOUT: cfg_q.lockout_ticks <= pwdata[9:0];
				REG_AMP:     cfg_q.amplitude     <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TICK:    prdata = {24'd0, cfg_q.tick_ms};
			REG_TIER1:   prdata = {16'd0, cfg_q.tier1_ms};
			REG_TIER2:   prdata = {16'd0, cfg_q.tier2_ms};
			REG_TIER3:   prdata = {16'd0, cfg_q.tier3_ms};
			REG_TIER4:   prdata = {16'd0, cfg_q.tier4_ms};
			REG_LOCKOUT: prdata = {22'd0, cfg_q.lockout_ticks};
			REG_AMP:     prdata = {28'd0, cfg_q.amplitude};
			default:     prdata = 32'd0;
		endcase
	end

endmodule

### design/bmmg_lane.sv
// One direction lane: hold-time tracker and speed tier select.
// Depends on bmmg_pkg.
module bmmg_lane import bmmg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctl_t          ctl,
	input  logic               pressed,
	input  cfg_t               cfg,
	output logic [SPEED_W-1:0] speed_s1
);

	logic [15:0]        hold_q;
	logic               track_q;
	logic [16:0]        hold_sum;
	logic [15:0]        hold_adv;
	logic [15:0]        hold_eff;
	logic [SPEED_W-1:0] speed;

	// while a press is tracked, wall time advances on every accepted request, saturating
	assign hold_sum = {1'b0, hold_q} + 17'(cfg.tick_ms);
	assign hold_adv = !track_q ? hold_q : (hold_sum[16] ? 16'hFFFF : hold_sum[15:0]);
	// a fresh press starts from zero
	assign hold_eff = track_q ? hold_adv : 16'd0;

	always_comb begin
		if (hold_eff > cfg.tier4_ms)      speed = SPEED_W'(8);
		else if (hold_eff > cfg.tier3_ms) speed = SPEED_W'(5);
		else if (hold_eff > cfg.tier2_ms) speed = SPEED_W'(4);
		else if (hold_eff > cfg.tier1_ms) speed = SPEED_W'(2);
		else                              speed = SPEED_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= 16'd0;
			track_q <= 1'b0;
		end else if (ctl.accept) begin
			if (ctl.manual) begin
				if (pressed) begin
					track_q <= 1'b1;
					hold_q  <= hold_eff;
				end else begin
					track_q <= 1'b0;
					hold_q  <= 16'd0;
				end
			end else begin
				hold_q <= hold_adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			speed_s1 <= (ctl.manual && pressed) ? speed : '0;
		end
	end

endmodule

### design/bmmg_merge.sv
// Merge stage: sums lane speeds per axis for manual mode, or maps the
// circle phase to scaled cos/sin. Depends on bmmg_pkg.
module bmmg_merge import bmmg_pkg::*; (
	input  stage_t                            stage,
	input  logic [NUM_DIRS-1:0][SPEED_W-1:0]  speeds,
	input  logic [3:0]                        amplitude,
	output result_t                           result
);

	logic signed [SUM_W-1:0] sx, sy, cx, cy;
	logic [5:0]              ang, ang_c, cand;
	logic [12:0]             mag_x, mag_y;
	logic [16:0]             prod_x, prod_y;
	logic [7:0]              px, py;
	logic [7:0]              man_x, man_y, cir_x, cir_y;

	// per-axis sum of lane speeds
	always_comb begin
		sx = '0;
		sy = '0;
		for (int i = 0; i < NUM_DIRS; i++) begin
			case (2'(i))
				2'd0:    sy = sy - SUM_W'(speeds[i]);
				2'd1:    sy = sy + SUM_W'(speeds[i]);
				2'd2:    sx = sx - SUM_W'(speeds[i]);
				2'd3:    sx = sx + SUM_W'(speeds[i]);
				default: ;
			endcase
		end
		cx = (sx > SUM_MAX) ? SUM_MAX : ((sx < SUM_MIN) ? SUM_MIN : sx);
		cy = (sy > SUM_MAX) ? SUM_MAX : ((sy < SUM_MIN) ? SUM_MIN : sy);
		man_x = 8'(cx);
		man_y = 8'(cy);
	end

	// angle index by binary search over the threshold table, MSB first
	always_comb begin
		ang = '0;
		for (int b = 5; b >= 0; b--) begin
			cand = ang | (6'd1 << b);
			if (stage.phase >= ANGLE_THR[cand]) ang = cand;
		end
	end

	// cos is sine a quarter turn ahead
	assign ang_c = ang + 6'd16;

	always_comb begin
		mag_x  = ang_c[4] ? QSIN[5'd16 - {1'b0, ang_c[3:0]}] : QSIN[{1'b0, ang_c[3:0]}];
		mag_y  = ang[4]   ? QSIN[5'd16 - {1'b0, ang[3:0]}]   : QSIN[{1'b0, ang[3:0]}];
		prod_x = 17'(amplitude) * 17'(mag_x);
		prod_y = 17'(amplitude) * 17'(mag_y);
		px     = {3'd0, prod_x[16:12]};
		py     = {3'd0, prod_y[16:12]};
		cir_x  = ang_c[5] ? -px : px;
		cir_y  = ang[5]   ? -py : py;
	end

	always_comb begin
		result.report_valid = stage.report;
		result.mode_led     = stage.circle;
		if (!stage.report) begin
			result.move_x = 8'd0;
			result.move_y = 8'd0;
		end else if (stage.circle) begin
			result.move_x = cir_x;
			result.move_y = cir_y;
		end else begin
			result.move_x = man_x;
			result.move_y = man_y;
		end
	end

endmodule

### design/button_mouse_motion_generator.sv
// Button mouse motion generator: one report per tick request.
// A request goes through the stage 1 register, then the output register;
// throughput one request per cycle while m_tready keeps the output moving.
// An output register and the stage 1 register each advance when free.
// Reset (arst_n low, async): manual mode, button released, no holds,
// phase and lockout zero, registers at their defaults; both stages empty.
module button_mouse_motion_generator import bmmg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// tick request
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] dir_pressed, [4] mode_level, [5] host_ready
	// report
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] report_valid, [8:1] move_x, [16:9] move_y,
	                               // [17] mode_led
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg;

	bmmg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------------------------------------------------------
	// Handshake: each stage moves when the one after it has room
	// ---------------------------------------------------------------
	logic    valid_s1;
	logic    out_valid_q;
	result_t out_data_q;
	logic    out_ready;
	logic    s1_ready;
	logic    accept;

	assign out_ready = !out_valid_q || m_tready;
	assign s1_ready  = !valid_s1 || out_ready;
	assign s_tready  = s1_ready;
	assign accept    = s_tvalid && s_tready;

	// ---------------------------------------------------------------
	// Mode button, lockout and circle phase
	// ---------------------------------------------------------------
	logic [3:0]            dir_pressed;
	logic                  mode_level, host_ready;
	logic                  circle_q, prev_level_q;
	logic [9:0]            lockout_q;
	logic [PHASE_BITS-1:0] phase_q;

	logic                  locked, fall, blocked, report, circle_nxt;
	logic [PHASE_BITS-1:0] phase_add, phase_nxt;

	assign dir_pressed = s_tdata[3:0];
	assign mode_level  = s_tdata[4];
	assign host_ready  = s_tdata[5];

	// during lockout nothing is sampled: no toggle, no report
	assign locked     = lockout_q != 10'd0;
	assign fall       = !locked && !mode_level && prev_level_q;
	// a toggle with zero lockout still reports on the same tick
	assign blocked    = fall && (cfg.lockout_ticks != 10'd0);
	assign report     = !locked && !blocked && host_ready;
	assign circle_nxt = circle_q ^ fall;

	// step, then wrap once
	assign phase_add = phase_q + PHASE_STEP;
	assign phase_nxt = (phase_add >= PHASE_WRAP) ? (phase_add - PHASE_WRAP) : phase_add;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circle_q     <= 1'b0;
			prev_level_q <= 1'b1;
			lockout_q    <= 10'd0;
			phase_q      <= '0;
		end else if (accept) begin
			if (locked) begin
				lockout_q <= lockout_q - 10'd1;
			end else begin
				prev_level_q <= mode_level;
				if (fall) begin
					circle_q  <= circle_nxt;
					lockout_q <= cfg.lockout_ticks;
				end
				if (report && circle_nxt) begin
					phase_q <= phase_nxt;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Direction lanes: one hold tracker per button, side by side
	// ---------------------------------------------------------------
	lane_ctl_t                        lane_ctl;
	logic [NUM_DIRS-1:0][SPEED_W-1:0] speed_s1;

	assign lane_ctl.accept = accept;
	assign lane_ctl.manual = report && !circle_nxt;

	for (genvar i = 0; i < NUM_DIRS; i++) begin : g_lane
		logic pressed;
		if (i < DIR_BTNS) begin : g_btn
			assign pressed = dir_pressed[i];
		end else begin : g_none
			// directions beyond the four buttons stay released
			assign pressed = 1'b0;
		end
		bmmg_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (lane_ctl),
			.pressed  (pressed),
			.cfg      (cfg),
			.speed_s1 (speed_s1[i])
		);
	end

	// ---------------------------------------------------------------
	// Stage 1 register
	// ---------------------------------------------------------------
	stage_t stage_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.report <= report;
			stage_s1.circle <= circle_nxt;
			stage_s1.phase  <= phase_nxt;
		end
	end

	// ---------------------------------------------------------------
	// Merge and output register
	// ---------------------------------------------------------------
	result_t merged;

	bmmg_merge u_merge (
		.stage     (stage_s1),
		.speeds    (speed_s1),
		.amplitude (cfg.amplitude),
		.result    (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s1) begin
			out_data_q <= merged;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_data_q};

endmodule
